// ===== hdl/fkvt_pkg.sv =====
`default_nettype none
package fkvt_pkg;
    localparam int MAX_BUCKETS = 1024;
    localparam int WAYS = 4;
    localparam int BKT_W = $clog2(MAX_BUCKETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ADDR_W = BKT_W + $clog2(WAYS);
    localparam int DEPTH = MAX_BUCKETS * WAYS;
    localparam int CNT_W = 11;
    localparam int KEY_W = 96;
    localparam int VAL_W = 32;
    localparam int HASH_W = 64;
    localparam int ENT_W = 1 + KEY_W + VAL_W;
    localparam int QDEPTH = 2;

    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_HIT = 3'd3;
    localparam logic [2:0] ST_MISS = 3'd4;

    typedef struct packed {
        logic op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [BKT_W-1:0] bucket;
    } req_t;
endpackage
`default_nettype wire

// ===== hdl/fkvt_ram.sv =====
`default_nettype none
module fkvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(DEPTH)-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/fkvt_front.sv =====
`default_nettype none
module fkvt_front (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    output logic busy,
    input wire logic op,
    input wire logic [fkvt_pkg::KEY_W-1:0] key,
    input wire logic [fkvt_pkg::VAL_W-1:0] value,
    input wire logic [fkvt_pkg::CNT_W-1:0] bucket_count,
    input wire logic q_full,
    output logic q_push,
    output fkvt_pkg::req_t q_data
);
    import fkvt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [6:0] step_reg, step_next;
    logic [HASH_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] div_reg, div_next;
    logic op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0] div_in;
    logic [CNT_W:0] trial;
    logic [CNT_W:0] shifted;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        if (bucket_count == '0)
        begin
            div_in = CNT_W'(1);
        end
        else if (bucket_count > CNT_W'(MAX_BUCKETS))
        begin
            div_in = CNT_W'(MAX_BUCKETS);
        end
        else
        begin
            div_in = bucket_count;
        end
    end

    assign shifted = {rem_reg, quo_reg[HASH_W-1]};
    assign trial = shifted - {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        op_next = op_reg;
        key_next = key_reg;
        val_next = val_reg;
        q_push = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = op;
                    key_next = key;
                    val_next = value;
                    div_next = div_in;
                    quo_next = key[95:32] ^ {48'd0, key[31:16]} ^ {48'd0, key[15:0]};
                    rem_next = '0;
                    step_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!trial[CNT_W])
                begin
                    rem_next = trial[CNT_W-1:0];
                end
                else
                begin
                    rem_next = shifted[CNT_W-1:0];
                end
                quo_next = {quo_reg[HASH_W-2:0], 1'b0};
                step_next = step_reg + 7'd1;
                if (step_reg == 7'(HASH_W - 1))
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!q_full)
                begin
                    q_push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign q_data = '{op: op_reg, key: key_reg, value: val_reg,
                      bucket: rem_reg[BKT_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        op_reg <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
    end
endmodule
`default_nettype wire

// ===== hdl/fkvt_queue.sv =====
`default_nettype none
module fkvt_queue (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    input wire fkvt_pkg::req_t push_data,
    output logic full,
    input wire logic pop,
    output logic empty,
    output fkvt_pkg::req_t pop_data
);
    import fkvt_pkg::*;

    req_t slot_reg [QDEPTH];
    logic [0:0] wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full = (cnt_reg == 2'(QDEPTH));
    assign empty = (cnt_reg == 2'd0);
    assign pop_data = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/fkvt_back.sv =====
`default_nettype none
module fkvt_back (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic q_empty,
    input wire fkvt_pkg::req_t q_data,
    output logic q_pop,
    output logic done,
    output logic [2:0] status,
    output logic [fkvt_pkg::VAL_W-1:0] found_value
);
    import fkvt_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_READ = 3'd1;
    localparam logic [2:0] B_CMP = 3'd2;
    localparam logic [2:0] B_DONE = 3'd3;
    localparam logic [2:0] B_CLEAR = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [WAY_W:0] way_reg, way_next;
    logic [WAY_W:0] match_reg, match_next;
    logic [WAY_W:0] free_reg, free_next;
    logic [VAL_W-1:0] mval_reg, mval_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [2:0] status_reg, status_next;
    logic [VAL_W-1:0] found_reg, found_next;
    logic done_reg, done_next;
    req_t cur_reg, cur_next;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [ENT_W-1:0] rdata, wdata;
    logic we;
    logic [ADDR_W-1:0] cur_addr;

    assign cur_addr = {cur_reg.bucket, way_reg[WAY_W-1:0]};
    assign raddr = cur_addr;

    fkvt_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        way_next = way_reg;
        match_next = match_reg;
        free_next = free_reg;
        mval_next = mval_reg;
        clr_next = clr_reg;
        cur_next = cur_reg;
        status_next = status_reg;
        found_next = found_reg;
        done_next = 1'b0;
        q_pop = 1'b0;
        we = 1'b0;
        waddr = cur_addr;
        wdata = {1'b1, cur_reg.key, cur_reg.value};
        case (state_reg)
            B_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    cur_next = q_data;
                    way_next = '0;
                    match_next = {1'b1, WAY_W'(0)};
                    free_next = {1'b1, WAY_W'(0)};
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_CMP;
            end
            B_CMP:
            begin
                if (rdata[ENT_W-1])
                begin
                    if (match_reg[WAY_W] && rdata[KEY_W+VAL_W-1:VAL_W] == cur_reg.key)
                    begin
                        match_next = way_reg;
                        mval_next = rdata[VAL_W-1:0];
                    end
                end
                else if (free_reg[WAY_W])
                begin
                    free_next = way_reg;
                end
                if (way_reg == (WAY_W+1)'(WAYS - 1))
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    way_next = way_reg + 1'b1;
                    state_next = B_READ;
                end
            end
            B_DONE:
            begin
                found_next = '0;
                done_next = 1'b1;
                state_next = B_IDLE;
                if (cur_reg.op == OP_SET)
                begin
                    if (!match_reg[WAY_W])
                    begin
                        we = 1'b1;
                        waddr = {cur_reg.bucket, match_reg[WAY_W-1:0]};
                        status_next = ST_UPDATED;
                    end
                    else if (!free_reg[WAY_W])
                    begin
                        we = 1'b1;
                        waddr = {cur_reg.bucket, free_reg[WAY_W-1:0]};
                        status_next = ST_INSERTED;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                else if (!match_reg[WAY_W])
                begin
                    found_next = mval_reg;
                    status_next = ST_HIT;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign status = status_reg;
    assign found_value = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            done_reg <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        way_reg <= way_next;
        match_reg <= match_next;
        free_reg <= free_next;
        mval_reg <= mval_next;
        cur_reg <= cur_next;
        status_reg <= status_next;
        found_reg <= found_next;
    end
endmodule
`default_nettype wire

// ===== hdl/flow_key_value_table.sv =====
// Flow key/value table: exact-match lookup and update of 32-bit values keyed
// by (src_ip, dst_ip, sport, dport), up to 4 ways per bucket.
// Request channel: raise start with the fields; the request is taken at a
// clock edge where start is high and busy is low.
// Result channel: done pulses for one cycle with status and found_value;
// the receiver cannot stall, so every result must be taken in that cycle.
// Front end computes the bucket with a bit-serial remainder, then pushes the
// request into the queue, waiting while it is full; busy stays high until then.
// Back end reads each way of the bucket from the entry RAM in turn, a read
// state then a compare state; a set that finds a match or a free way writes
// the entry in the done state. A two-slot queue joins the two halves.
// bucket_count must be written through cfg_we/cfg_data only while idle, which
// the block does not enforce; 0 acts as 1 and values above 1024 act as 1024.
// Reset sets bucket_count to 1024 and starts a pass that clears every entry;
// requests taken meanwhile wait in the queue or the front end, so the first
// results come only after that pass.
`default_nettype none
module flow_key_value_table (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    output logic busy,
    input wire logic cfg_we,
    input wire logic [10:0] cfg_data,
    input wire logic opcode,
    input wire logic [31:0] src_ip,
    input wire logic [31:0] dst_ip,
    input wire logic [15:0] sport,
    input wire logic [15:0] dport,
    input wire logic [31:0] new_value,
    output logic done,
    output logic [2:0] status,
    output logic [31:0] found_value
);
    import fkvt_pkg::*;

    logic [CNT_W-1:0] bcnt_reg;
    logic q_push, q_full, q_pop, q_empty;
    req_t q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg <= CNT_W'(MAX_BUCKETS);
        end
        else if (cfg_we)
        begin
            bcnt_reg <= cfg_data;
        end
    end

    fkvt_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(opcode),
        .key({src_ip, dst_ip, sport, dport}), .value(new_value),
        .bucket_count(bcnt_reg), .q_full(q_full), .q_push(q_push), .q_data(q_in)
    );

    fkvt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .empty(q_empty), .pop_data(q_out)
    );

    fkvt_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
        .done(done), .status(status), .found_value(found_value)
    );
endmodule
`default_nettype wire

// ===== hdl/fkvt_checker.sv =====
`default_nettype none
module fkvt_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic [2:0] status,
    input wire logic [31:0] found_value
);
    import fkvt_pkg::*;

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_MISS) else $error("bad status");
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_HIT |-> found_value == 32'd0) else $error("value not zero");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
endmodule

bind flow_key_value_table fkvt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .found_value(found_value)
);
`default_nettype wire
